/* sv/mft_pkg.sv */
// Shared types, constants and modular arithmetic for the modular Fenwick tree.
package mft_pkg;

    // Field widths fixed by the request and result formats.
    localparam int IDX_W = 11;
    localparam int VAL_W = 30;
    // Walk position: an index plus its lowest set bit needs one more bit.
    localparam int POS_W = IDX_W + 1;

    localparam logic [VAL_W-1:0] PRIME_MOD  = 30'd1000000007;
    localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

    // Request type codes.
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Status codes.
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Port controls of the tree memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    // Sum of two residues, both below the modulus, reduced once.
    function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME_MOD})
        begin
            s = s - {1'b0, PRIME_MOD};
        end
        return s[VAL_W-1:0];
    endfunction

    // Reduce a raw 30-bit value, which is always below twice the modulus.
    function automatic logic [VAL_W-1:0] mod_reduce(input logic [VAL_W-1:0] a);
        logic [VAL_W-1:0] r;
        r = a;
        if (a >= PRIME_MOD)
        begin
            r = a - PRIME_MOD;
        end
        return r;
    endfunction

endpackage

/* sv/mft_store.sv */
// Tree memory: one write port and one read port with registered read data.
module mft_store #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                     clk,
    input  mft_pkg::mem_ctl_t        ctl,
    input  logic [AW-1:0]            waddr,
    input  logic [mft_pkg::VAL_W-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic [mft_pkg::VAL_W-1:0] rdata
);
    import mft_pkg::*;

    logic [VAL_W-1:0] mem_array [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Read port; read data is registered.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem_array[raddr];
        end
    end

endmodule

/* sv/mft_ctrl.sv */
// Walk sequencer: clearing pass, add and query walks over the tree memory, result register.
module mft_ctrl #(
    parameter int MAX_SIZE = 1024,
    localparam int AW = $clog2(MAX_SIZE)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [mft_pkg::IDX_W-1:0] size_in_use,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [mft_pkg::IDX_W-1:0] index,
    input  logic [mft_pkg::VAL_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mft_pkg::VAL_W-1:0] prefix_sum,
    output logic                      status,
    output mft_pkg::mem_ctl_t         mem_ctl,
    output logic [AW-1:0]             mem_waddr,
    output logic [mft_pkg::VAL_W-1:0] mem_wdata,
    output logic [AW-1:0]             mem_raddr,
    input  logic [mft_pkg::VAL_W-1:0] mem_rdata
);
    import mft_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_STEP  = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             query_reg, query_next;
    logic [VAL_W-1:0] amount_reg, amount_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0] hold_sum_reg, hold_sum_next;
    logic             hold_status_reg, hold_status_next;
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_sum_reg;
    logic             out_status_reg;

    logic [IDX_W-1:0] eff_size;
    logic             out_free;
    logic             load_out;
    logic [VAL_W-1:0] load_sum;
    logic             load_status;
    logic             reject;
    logic [POS_W-1:0] low_bit;
    logic [POS_W-1:0] pos_step;
    logic [VAL_W-1:0] acc_sum;
    logic             walk_more;

    // Size in use, capped at the tree capacity.
    always_comb
    begin
        if (32'(size_in_use) > MAX_SIZE)
        begin
            eff_size = IDX_W'(MAX_SIZE);
        end
        else
        begin
            eff_size = size_in_use;
        end
    end

    // Request check: out-of-range index, and index zero on an add.
    assign reject = (index > eff_size) || ((req_type == REQ_ADD) && (index == '0));

    // Next position on the walk: upward for adds, downward for queries.
    assign low_bit = pos_reg & (~pos_reg + 1'b1);
    assign acc_sum = mod_add(acc_reg, mem_rdata);
    always_comb
    begin
        if (query_reg)
        begin
            pos_step  = pos_reg & (pos_reg - 1'b1);
            walk_more = (pos_step != '0);
        end
        else
        begin
            pos_step  = pos_reg + low_bit;
            walk_more = (pos_step <= {1'b0, eff_size});
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        pos_next         = pos_reg;
        query_next       = query_reg;
        amount_next      = amount_reg;
        acc_next         = acc_reg;
        hold_sum_next    = hold_sum_reg;
        hold_status_next = hold_status_reg;
        mem_ctl          = '0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_raddr        = '0;
        load_out         = 1'b0;
        load_sum         = '0;
        load_status      = STATUS_OK;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = clr_reg;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (reject || (index == '0))
                    begin
                        // Rejected request, or a query at zero: answer at once.
                        load_status = reject ? STATUS_REJECT : STATUS_OK;
                        if (out_free)
                        begin
                            load_out = 1'b1;
                        end
                        else
                        begin
                            hold_sum_next    = '0;
                            hold_status_next = load_status;
                            state_next       = ST_HOLD;
                        end
                    end
                    else
                    begin
                        // Start the walk with a read of the first entry.
                        mem_ctl.rd_en = 1'b1;
                        mem_raddr     = AW'(index - 1'b1);
                        pos_next      = {1'b0, index};
                        query_next    = (req_type == REQ_QUERY);
                        amount_next   = mod_reduce(value);
                        acc_next      = '0;
                        state_next    = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                // Entry at pos_reg is on the read port; write back for adds.
                if (query_reg)
                begin
                    acc_next = acc_sum;
                end
                else
                begin
                    mem_ctl.wr_en = 1'b1;
                    mem_waddr     = AW'(pos_reg - 1'b1);
                    mem_wdata     = mod_add(mem_rdata, amount_reg);
                end
                if (walk_more)
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_raddr     = AW'(pos_step - 1'b1);
                    pos_next      = pos_step;
                end
                else
                begin
                    load_sum = query_reg ? acc_sum : '0;
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        hold_sum_next    = load_sum;
                        hold_status_next = STATUS_OK;
                        state_next       = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                load_sum    = hold_sum_reg;
                load_status = hold_status_reg;
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk and result payload.
    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        query_reg       <= query_next;
        amount_reg      <= amount_next;
        acc_reg         <= acc_next;
        hold_sum_reg    <= hold_sum_next;
        hold_status_reg <= hold_status_next;
        if (load_out)
        begin
            out_sum_reg    <= load_sum;
            out_status_reg <= load_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign prefix_sum = out_sum_reg;
    assign status     = out_status_reg;

    // The walk never reads the entry it writes in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en && mem_ctl.rd_en) |-> (mem_waddr != mem_raddr))
        else $error("tree read and write hit the same entry");

    // Stored entries stay reduced.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> (mem_wdata < PRIME_MOD))
        else $error("unreduced tree entry written");

    // Walk position is a live tree position within the size in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> ((pos_reg != '0) && (pos_reg <= {1'b0, eff_size})))
        else $error("walk position out of range");

    // A result is only loaded when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("result overwrote a pending item");

endmodule

/* sv/modular_fenwick_tree.sv */
// Operation: a request that walks k tree entries, k at most log2(MAX_SIZE)+1, has its result
// registered on the last walk step; a rejected request or a query at zero has it registered at the
// accepting edge. Either waits in ST_HOLD while the output is busy. A new request is taken only in
// idle; the walk visits one entry per cycle through the single read port.
// Reset: a clearing pass zeroes every tree entry with in_ready low;
// configuration writes are taken throughout.
module modular_fenwick_tree #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [mft_pkg::IDX_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [mft_pkg::IDX_W-1:0] index,
    input  logic [mft_pkg::VAL_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mft_pkg::VAL_W-1:0] prefix_sum,
    output logic                      status
);
    import mft_pkg::*;

    localparam int AW = $clog2(MAX_SIZE);

    logic [IDX_W-1:0] size_reg;
    mem_ctl_t         mem_ctl;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [VAL_W-1:0] mem_rdata;

    // Size register, always writable.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            size_reg <= cfg_data;
        end
    end

    mft_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .size_in_use (size_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .index       (index),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .prefix_sum  (prefix_sum),
        .status      (status),
        .mem_ctl     (mem_ctl),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    mft_store #(
        .DEPTH (MAX_SIZE)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
